@@ hdl/ptg_pkg.sv @@
// ----------------------------------------------------------------------------
// ptg_pkg
// Types, constants and the arctangent table of the go-to-goal controller.
// ----------------------------------------------------------------------------
package ptg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int N_CORDIC      = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                   : ATAN_ENTRIES;
    localparam int CW            = 38;   // CORDIC x/y width
    localparam int ZW            = 34;   // CORDIC angle width, Q30
    localparam int AW            = 20;   // angle width, signed Q4.16
    localparam int EW            = 22;   // heading error width
    localparam int SQ_BITS       = 32;   // root bits
    localparam int SQ_LAT        = 3 + SQ_BITS;
    localparam int CORDIC_LAT    = N_CORDIC + 2;
    localparam int ANG_DLY       = SQ_LAT - CORDIC_LAT;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [2:0] {
        REG_GOAL_X   = 3'd0,
        REG_GOAL_Y   = 3'd1,
        REG_GAIN     = 3'd2,
        REG_ANG_TOL  = 3'd3,
        REG_DIST_TOL = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_TURN  = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_DONE  = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in;

    typedef struct packed {
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic [1:0]         drive_mode;
    } t_out;

    typedef struct packed {
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic [15:0]        gain;
        logic [19:0]        angle_tolerance;
        logic [19:0]        distance_tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [33:0] sy;
        logic signed [33:0] cy;
    } t_work;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ptg_front.sv @@
// ----------------------------------------------------------------------------
// ptg_front
// Accepts odometry beats: goal error and quaternion yaw terms.
// ----------------------------------------------------------------------------
module ptg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  ptg_pkg::t_in  i_item,
    input  ptg_pkg::t_cfg i_cfg,
    output logic          o_push,
    output ptg_pkg::t_work o_work
);

    logic               r_v;
    logic signed [32:0] r_ex, r_ey;
    logic signed [31:0] r_pwz, r_pxy, r_pyy, r_pzz;
    logic signed [32:0] s_sum_s, s_sum_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ex  <= 33'(i_cfg.goal_x) - 33'(i_item.pos_x);
        r_ey  <= 33'(i_cfg.goal_y) - 33'(i_item.pos_y);
        r_pwz <= i_item.quat_w * i_item.quat_z;
        r_pxy <= i_item.quat_x * i_item.quat_y;
        r_pyy <= i_item.quat_y * i_item.quat_y;
        r_pzz <= i_item.quat_z * i_item.quat_z;
    end

    always_comb begin
        s_sum_s   = 33'(r_pwz) + 33'(r_pxy);
        s_sum_c   = 33'(r_pyy) + 33'(r_pzz);
        o_push    = r_v;
        o_work.ex = r_ex;
        o_work.ey = r_ey;
        o_work.sy = 34'(s_sum_s) <<< 1;
        o_work.cy = 34'sd268435456 - (34'(s_sum_c) <<< 1);
    end

endmodule

@@ hdl/ptg_queue.sv @@
// ----------------------------------------------------------------------------
// ptg_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module ptg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptg_pkg::t_work i_work,
    output logic           o_pop,
    output ptg_pkg::t_work o_work,
    output logic           o_busy
);

    ptg_pkg::t_work               r_mem [0:ptg_pkg::QDEPTH-1];
    logic [ptg_pkg::QAW-1:0]      r_wr, r_rd;
    logic [ptg_pkg::QAW:0]        r_cnt;

    assign o_pop  = (r_cnt != '0);
    assign o_work = r_mem[r_rd];
    assign o_busy = (r_cnt >= (ptg_pkg::QAW+1)'(ptg_pkg::QDEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (o_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (ptg_pkg::QAW+1)'(i_push) - (ptg_pkg::QAW+1)'(o_pop);
        end
    end

endmodule

@@ hdl/ptg_cordic.sv @@
// ----------------------------------------------------------------------------
// ptg_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in signed Q4.16 radians.
// ----------------------------------------------------------------------------
module ptg_cordic (
    input  logic                              i_clk,
    input  logic signed [ptg_pkg::CW-1:0]     i_y,
    input  logic signed [ptg_pkg::CW-1:0]     i_x,
    output logic signed [ptg_pkg::AW-1:0]     o_ang
);

    localparam int N = ptg_pkg::N_CORDIC;

    logic signed [ptg_pkg::CW-1:0] r_x [0:N];
    logic signed [ptg_pkg::CW-1:0] r_y [0:N];
    logic signed [ptg_pkg::ZW-1:0] r_z [0:N];
    logic [N:0]                    r_zero;
    logic signed [ptg_pkg::ZW-1:0] s_round;
    logic signed [ptg_pkg::AW-1:0] r_ang;

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            if (i_y >= 0) begin
                r_x[0] <= i_y;
                r_y[0] <= -i_x;
                r_z[0] <= ptg_pkg::HALF_PI_Q30;
            end else begin
                r_x[0] <= -i_y;
                r_y[0] <= i_x;
                r_z[0] <= -ptg_pkg::HALF_PI_Q30;
            end
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ptg_pkg::atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ptg_pkg::atan_q30(i);
            end
        end
    end

    assign s_round = (r_z[N] + ptg_pkg::ZW'(8192)) >>> 14;

    always_ff @(posedge i_clk) begin
        r_ang <= r_zero[N] ? '0 : s_round[ptg_pkg::AW-1:0];
    end

    assign o_ang = r_ang;

endmodule

@@ hdl/ptg_back.sv @@
// ----------------------------------------------------------------------------
// ptg_back
// Yaw, bearing and distance pipelines, mode decision and gain scaling.
// ----------------------------------------------------------------------------
module ptg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop,
    input  ptg_pkg::t_work i_work,
    input  ptg_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    output ptg_pkg::t_out  o_result
);

    localparam int SB = ptg_pkg::SQ_BITS;
    localparam int RW = 2 * SB - 1;
    localparam int SW = RW + 3;
    localparam int D  = ptg_pkg::ANG_DLY;
    localparam int L  = ptg_pkg::SQ_LAT;

    ptg_pkg::t_work r_w;
    logic [L:0]     r_vl;

    logic signed [ptg_pkg::AW-1:0] s_yaw, s_brg;
    logic signed [ptg_pkg::AW-1:0] r_yaw_d [0:D-1];
    logic signed [ptg_pkg::AW-1:0] r_brg_d [0:D-1];

    logic [31:0]   s_ax, s_ay;
    logic [30:0]   r_ax, r_ay;
    logic [L-1:0]  r_sh;
    logic [61:0]   r_sqx, r_sqy;
    logic [RW-1:0] r_rem  [0:SB];
    logic [SB-1:0] r_root [0:SB];

    logic signed [ptg_pkg::EW-1:0] s_err;
    logic [ptg_pkg::EW-1:0]        s_aerr;
    logic [32:0]                   s_dist;
    logic signed [33:0]            n_sel, r_sel;
    ptg_pkg::t_mode                n_mode, r_mode, r_mode_m;
    logic                          r_v_dec, r_v_mul, r_v_out;
    logic signed [50:0]            r_prod;
    logic signed [51:0]            s_rnd;
    logic signed [31:0]            s_sat;
    ptg_pkg::t_out                 r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl    <= '0;
            r_v_dec <= 1'b0;
            r_v_mul <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            r_vl    <= {r_vl[L-1:0], i_pop};
            r_v_dec <= r_vl[L];
            r_v_mul <= r_v_dec;
            r_v_out <= r_v_mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_w <= i_work;
        end
    end

    ptg_cordic u_yaw (
        .i_clk (i_clk),
        .i_y   (ptg_pkg::CW'(r_w.sy)),
        .i_x   (ptg_pkg::CW'(r_w.cy)),
        .o_ang (s_yaw)
    );

    ptg_cordic u_brg (
        .i_clk (i_clk),
        .i_y   (ptg_pkg::CW'(r_w.ey)),
        .i_x   (ptg_pkg::CW'(r_w.ex)),
        .o_ang (s_brg)
    );

    always_ff @(posedge i_clk) begin
        r_yaw_d[0] <= s_yaw;
        r_brg_d[0] <= s_brg;
    end

    for (genvar k = 1; k < D; k++) begin : g_adly
        always_ff @(posedge i_clk) begin
            r_yaw_d[k] <= r_yaw_d[k-1];
            r_brg_d[k] <= r_brg_d[k-1];
        end
    end

    always_comb begin
        s_ax = r_w.ex[32] ? 32'(-r_w.ex) : r_w.ex[31:0];
        s_ay = r_w.ey[32] ? 32'(-r_w.ey) : r_w.ey[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (s_ax[31] || s_ay[31]) begin
            r_ax <= s_ax[31:1];
            r_ay <= s_ay[31:1];
        end else begin
            r_ax <= s_ax[30:0];
            r_ay <= s_ay[30:0];
        end
        r_sh      <= {r_sh[L-2:0], s_ax[31] | s_ay[31]};
        r_sqx     <= r_ax * r_ax;
        r_sqy     <= r_ay * r_ay;
        r_rem[0]  <= RW'(r_sqx) + RW'(r_sqy);
        r_root[0] <= '0;
    end

    for (genvar j = 0; j < SB; j++) begin : g_sqrt
        localparam int K = SB - 1 - j;
        logic [SW-1:0] s_t;
        assign s_t = (SW'(r_root[j]) << (K + 1)) | (SW'(1) << (2 * K));
        always_ff @(posedge i_clk) begin
            if (SW'(r_rem[j]) >= s_t) begin
                r_rem[j+1]  <= r_rem[j] - s_t[RW-1:0];
                r_root[j+1] <= r_root[j] | (SB'(1) << K);
            end else begin
                r_rem[j+1]  <= r_rem[j];
                r_root[j+1] <= r_root[j];
            end
        end
    end

    always_comb begin
        s_err  = ptg_pkg::EW'(r_brg_d[D-1]) - ptg_pkg::EW'(r_yaw_d[D-1]);
        s_aerr = s_err[ptg_pkg::EW-1] ? ptg_pkg::EW'(-s_err) : s_err;
        s_dist = r_sh[L-1] ? {r_root[SB], 1'b0} : {1'b0, r_root[SB]};
        if (s_aerr > ptg_pkg::EW'(i_cfg.angle_tolerance)) begin
            n_mode = ptg_pkg::MODE_TURN;
            n_sel  = 34'(s_err);
        end else if (s_dist > 33'(i_cfg.distance_tolerance)) begin
            n_mode = ptg_pkg::MODE_DRIVE;
            n_sel  = $signed({1'b0, s_dist});
        end else begin
            n_mode = ptg_pkg::MODE_DONE;
            n_sel  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_mode   <= n_mode;
        r_prod   <= r_sel * $signed({1'b0, i_cfg.gain});
        r_mode_m <= r_mode;
    end

    always_comb begin
        s_rnd = (52'(r_prod) + 52'sd128) >>> 8;
        if (s_rnd > 52'sd2147483647) begin
            s_sat = 32'sh7FFFFFFF;
        end else if (s_rnd < -52'sd2147483648) begin
            s_sat = 32'sh80000000;
        end else begin
            s_sat = s_rnd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.drive_mode       <= r_mode_m;
        r_out.linear_velocity  <= (r_mode_m == ptg_pkg::MODE_DRIVE) ? s_sat : '0;
        r_out.angular_velocity <= (r_mode_m == ptg_pkg::MODE_TURN) ? s_sat : '0;
    end

    assign o_valid  = r_v_out;
    assign o_result = r_out;

endmodule

@@ hdl/pose_to_goal_p_controller.sv @@
// ----------------------------------------------------------------------------
// pose_to_goal_p_controller
// The path from the edge that accepts a beat to its result strobe is set by the
// 32-stage square root pipeline. Throughput: one beat per cycle; busy stays
// low since the back end never stalls. Reset: synchronous, active low; config
// registers return to goal (2.0, 3.0), gain 5.0, tolerances 0.1.
// ----------------------------------------------------------------------------
module pose_to_goal_p_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ptg_pkg::t_in  i_item,
    output logic          o_valid,
    output ptg_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    ptg_pkg::t_cfg  r_cfg;
    ptg_pkg::t_work s_fw, s_qw;
    logic           s_push, s_pop, s_take;

    assign s_take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x             <= 32'sd131072;
            r_cfg.goal_y             <= 32'sd196608;
            r_cfg.gain               <= 16'd1280;
            r_cfg.angle_tolerance    <= 20'd6554;
            r_cfg.distance_tolerance <= 20'd6554;
        end else if (i_cfg_we) begin
            unique case (ptg_pkg::t_reg_idx'(i_cfg_idx))
                ptg_pkg::REG_GOAL_X:   r_cfg.goal_x             <= i_cfg_data;
                ptg_pkg::REG_GOAL_Y:   r_cfg.goal_y             <= i_cfg_data;
                ptg_pkg::REG_GAIN:     r_cfg.gain               <= i_cfg_data[15:0];
                ptg_pkg::REG_ANG_TOL:  r_cfg.angle_tolerance    <= i_cfg_data[19:0];
                ptg_pkg::REG_DIST_TOL: r_cfg.distance_tolerance <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    ptg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (s_take),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_push  (s_push),
        .o_work  (s_fw)
    );

    ptg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_work  (s_fw),
        .o_pop   (s_pop),
        .o_work  (s_qw),
        .o_busy  (busy)
    );

    ptg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pop    (s_pop),
        .i_work   (s_qw),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the go-to-goal controller: odometry beats go in under random bursts
// and gaps, and each result strobe is compared against a bit-exact predictor
// of the yaw/bearing CORDIC, integer root and saturated gain scaling.
// ----------------------------------------------------------------------------
module testbench;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    ptg_pkg::t_in          i_item;
    logic                  o_valid;
    ptg_pkg::t_out         o_result;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_idx;
    logic [31:0]           i_cfg_data;

    pose_to_goal_p_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int LATENCY = 41;

    ptg_pkg::t_out cmd_q[$];
    int            errors;
    ptg_pkg::t_cfg cfg;
    int            burst_left;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint heading_q16(longint y, longint x);
        longint z, t, dx, dy;
        int n;
        n = (ptg_pkg::CORDIC_STAGES < 24) ? ptg_pkg::CORDIC_STAGES : 24;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 1686629713;
            end else begin
                t = x; x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < n; i++) begin
            dx = shr(y, i);
            dy = shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ptg_pkg::atan_q30(i));
            end else begin
                x -= dx; y += dy; z -= longint'(ptg_pkg::atan_q30(i));
            end
        end
        return shr(z + 8192, 14);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b; res = (res >> 1) + b;
            end else res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] gain_scaled(longint v);
        longint r;
        r = shr(v * longint'({1'b0, cfg.gain}) + 128, 8);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic ptg_pkg::t_out command_for(ptg_pkg::t_in s);
        ptg_pkg::t_out o;
        longint ex, ey, qx, qy, qz, qw, yaw, brg, err, aerr;
        longint unsigned ax, ay, span;
        bit halved;
        ex = longint'(cfg.goal_x) - longint'(s.pos_x);
        ey = longint'(cfg.goal_y) - longint'(s.pos_y);
        qx = s.quat_x; qy = s.quat_y; qz = s.quat_z; qw = s.quat_w;
        yaw = heading_q16(2 * (qw * qz + qx * qy), (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
        brg = heading_q16(ey, ex);
        err = brg - yaw;
        aerr = err < 0 ? -err : err;
        ax = ex < 0 ? -ex : ex;
        ay = ey < 0 ? -ey : ey;
        halved = (ax >= 64'd2147483648) || (ay >= 64'd2147483648);
        if (halved) begin
            ax >>= 1; ay >>= 1;
        end
        span = root_floor(ax * ax + ay * ay) << halved;
        o = '0;
        if (aerr > longint'({1'b0, cfg.angle_tolerance})) begin
            o.angular_velocity = gain_scaled(err);
            o.drive_mode = ptg_pkg::MODE_TURN;
        end else if (span > {44'd0, cfg.distance_tolerance}) begin
            o.linear_velocity = gain_scaled(longint'(span));
            o.drive_mode = ptg_pkg::MODE_DRIVE;
        end else o.drive_mode = ptg_pkg::MODE_DONE;
        return o;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        ptg_pkg::t_out want;
        if (i_rst_n && o_valid) begin
            if (cmd_q.size() == 0) report("unexpected beat", 0, 0);
            else begin
                want = cmd_q.pop_front();
                if (o_result.linear_velocity !== want.linear_velocity)
                    report("linear", o_result.linear_velocity, want.linear_velocity);
                if (o_result.angular_velocity !== want.angular_velocity)
                    report("angular", o_result.angular_velocity, want.angular_velocity);
                if (o_result.drive_mode !== want.drive_mode)
                    report("mode", o_result.drive_mode, want.drive_mode);
            end
        end
    end

    task automatic send(ptg_pkg::t_in s);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= s;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cmd_q.push_back(command_for(s));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(ptg_pkg::t_reg_idx idx, logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ptg_pkg::REG_GOAL_X:   cfg.goal_x = v;
            ptg_pkg::REG_GOAL_Y:   cfg.goal_y = v;
            ptg_pkg::REG_GAIN:     cfg.gain = v[15:0];
            ptg_pkg::REG_ANG_TOL:  cfg.angle_tolerance = v[19:0];
            default:               cfg.distance_tolerance = v[19:0];
        endcase
        @(posedge i_clk);
    endtask

    function automatic ptg_pkg::t_in pose(int px, int py, int qx, int qy, int qz, int qw);
        ptg_pkg::t_in s;
        s.pos_x = px; s.pos_y = py;
        s.quat_x = 16'(qx); s.quat_y = 16'(qy); s.quat_z = 16'(qz); s.quat_w = 16'(qw);
        return s;
    endfunction

    function automatic logic [15:0] quat_part();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 32768)) - 16'd16384;
            1: return 16'($urandom);
            2: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            default: return 16'($urandom_range(0, 2000)) - 16'd1000;
        endcase
    endfunction

    function automatic ptg_pkg::t_in random_pose();
        ptg_pkg::t_in s;
        int near;
        near = $urandom_range(0, 3);
        s.pos_x = (near == 0) ? cfg.goal_x + $signed($urandom_range(0, 16384)) - 8192
                 : (near == 1) ? $urandom : cfg.goal_x + $signed($urandom_range(0, 2097152)) - 1048576;
        s.pos_y = (near == 0) ? cfg.goal_y + $signed($urandom_range(0, 16384)) - 8192
                 : (near == 1) ? $urandom : cfg.goal_y + $signed($urandom_range(0, 2097152)) - 1048576;
        if ($urandom_range(0, 2) == 0) begin
            // zero heading; half the time the goal lies straight ahead so the drive and arrival branches are reached
            s.quat_x = '0; s.quat_y = '0; s.quat_z = '0; s.quat_w = 16'sd16384;
            if ($urandom_range(0, 1)) begin
                s.pos_y = cfg.goal_y;
                s.pos_x = cfg.goal_x - $signed($urandom_range(0, 4000000));
            end
        end else begin
            s.quat_x = quat_part(); s.quat_y = quat_part();
            s.quat_z = quat_part(); s.quat_w = quat_part();
        end
        return s;
    endfunction

    task automatic test_directed();
        send(pose(131072, 196608, 0, 0, 0, 16384));
        send(pose(0, 0, 0, 0, 0, 16384));
        send(pose(131072, 0, 0, 0, 0, 0));
        send(pose(1000000, 196608, 0, 0, 16384, 0));
        send(pose(1000000, 300000, 0, 0, 0, 16384));
        send(pose(1000000, 100000, 0, 0, 0, 16384));
        send(pose(32'h7fffffff, 32'h80000000, 0, 0, 0, 16384));
        send(pose(32'h80000000, 32'h7fffffff, 16384, 16384, 16384, 16384));
        send(pose(-500000, 196608, 0, 0, 0, 16384));
        send(pose(131072, 196608, -16384, -16384, -16384, -16384));
        send(pose(131072, 196608, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
        send(pose(131072, 196608, 16'hffff, 16'h1, 16'h5555, 16'haaaa));
        send(pose(131172, 196708, 0, 0, 0, 16384));
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(ptg_pkg::REG_GOAL_X, 32'h7fffffff);
        write_reg(ptg_pkg::REG_GOAL_Y, 32'h80000000);
        write_reg(ptg_pkg::REG_GAIN, 16'hffff);
        write_reg(ptg_pkg::REG_ANG_TOL, 20'hfffff);
        write_reg(ptg_pkg::REG_DIST_TOL, 0);
        repeat (8) send(random_pose());
        send(pose(32'h80000000, 32'h7fffffff, 0, 0, 0, 16384));
        drain();
        write_reg(ptg_pkg::REG_GOAL_X, 32'h80000000);
        write_reg(ptg_pkg::REG_GOAL_Y, 32'h7fffffff);
        write_reg(ptg_pkg::REG_GAIN, 0);
        write_reg(ptg_pkg::REG_ANG_TOL, 0);
        write_reg(ptg_pkg::REG_DIST_TOL, 20'hfffff);
        repeat (8) send(random_pose());
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 7; p++) begin
            write_reg(ptg_pkg::REG_GOAL_X,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000));
            write_reg(ptg_pkg::REG_GOAL_Y,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000000));
            write_reg(ptg_pkg::REG_GAIN, $urandom);
            write_reg(ptg_pkg::REG_ANG_TOL,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 60000));
            write_reg(ptg_pkg::REG_DIST_TOL,
                      $urandom_range(0, 1) ? $urandom : $urandom_range(0, 60000));
            repeat (245) send(random_pose());
            drain();
        end
    endtask

    initial begin
        errors = 0; burst_left = 0;
        start = 1'b0; i_item = '0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        cfg.goal_x = 131072; cfg.goal_y = 196608; cfg.gain = 1280;
        cfg.angle_tolerance = 6554; cfg.distance_tolerance = 6554;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random_phases();
        if (errors == 0 && cmd_q.size() == 0) $display("[pose_to_goal_p_controller] OK");
        else $display("[pose_to_goal_p_controller] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[pose_to_goal_p_controller] ERROR");
        $finish;
    end
endmodule
